>>> rtl/gbs_pkg.sv
// Shared types and constants of the greedy box suppression unit.
// No dependencies; every other file but gbs_ifs imports this package.
package gbs_pkg;

    // Register indexes of the configuration port.
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THR   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_THR = 4'd1;

    localparam logic [15:0] SCORE_THR_RESET   = 16'd19661;
    localparam logic [15:0] OVERLAP_THR_RESET = 16'd26214;

    // Register stages of the overlap pipeline between the chain head and its tail.
    localparam int IOU_LAT = 4;
    localparam int KEEP_W  = 6;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic [14:0]        width;
        logic [14:0]        height;
        logic [15:0]        score;
    } gbs_box_t;

    typedef struct packed {
        logic valid;
        logic done;
        logic removed;
    } gbs_flags_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic clear;
    } gbs_ctl_t;

    typedef enum logic {
        ST_LOAD,
        ST_WALK
    } gbs_state_t;

endpackage

>>> rtl/gbs_ifs.sv
// Channel interfaces of the greedy box suppression unit.
// Depends on nothing; instantiated by the top level's environment.
interface gbs_box_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] box_left;
    logic signed [15:0] box_top;
    logic [14:0]        box_width;
    logic [14:0]        box_height;
    logic [15:0]        score;
    logic               final_box;

    modport source (output valid, box_left, box_top, box_width, box_height, score,
                    final_box, input ready);
    modport sink (input valid, box_left, box_top, box_width, box_height, score,
                  final_box, output ready);
endinterface

interface gbs_res_if;
    logic       valid;
    logic       ready;
    logic [5:0] kept_index;
    logic       last_kept;
    logic       none_kept;
    logic       boxes_dropped;

    modport source (output valid, kept_index, last_kept, none_kept, boxes_dropped,
                    input ready);
    modport sink (input valid, kept_index, last_kept, none_kept, boxes_dropped,
                  output ready);
endinterface

interface gbs_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/gbs_cell.sv
// One cell of the box chain: holds one box, inserts by score, shifts to the head.
// Depends on gbs_pkg.
module gbs_cell
    import gbs_pkg::*;
#(
    parameter int IDX_W = 6
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  gbs_ctl_t         ctl,
    input  gbs_box_t         ins_box,
    input  logic [IDX_W-1:0] ins_idx,
    input  gbs_box_t         prev_box,
    input  gbs_flags_t       prev_flags,
    input  logic [IDX_W-1:0] prev_idx,
    input  logic             prev_gt,
    input  gbs_box_t         next_box,
    input  gbs_flags_t       next_flags,
    input  logic [IDX_W-1:0] next_idx,
    output gbs_box_t         box,
    output gbs_flags_t       flags,
    output logic [IDX_W-1:0] idx,
    output logic             gt
);

    gbs_box_t         box_reg, box_next;
    gbs_flags_t       flags_reg, flags_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    // An empty cell ranks below everything; equal scores keep arrival order.
    assign gt = !flags_reg.valid || (ins_box.score > box_reg.score);

    always_comb
    begin
        box_next   = box_reg;
        flags_next = flags_reg;
        idx_next   = idx_reg;
        if (ctl.clear)
        begin
            flags_next = '0;
        end
        else if (ctl.load)
        begin
            if (gt && !prev_gt)
            begin
                box_next   = ins_box;
                idx_next   = ins_idx;
                flags_next = '{valid: 1'b1, done: 1'b0, removed: 1'b0};
            end
            else if (gt)
            begin
                box_next   = prev_box;
                idx_next   = prev_idx;
                flags_next = prev_flags;
            end
        end
        else if (ctl.shift)
        begin
            box_next   = next_box;
            idx_next   = next_idx;
            flags_next = next_flags;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        box_reg <= box_next;
        idx_reg <= idx_next;
    end

    assign box   = box_reg;
    assign flags = flags_reg;
    assign idx   = idx_reg;

endmodule

>>> rtl/gbs_iou.sv
// Overlap pipeline: tests each passing box against the kept box, marks it removed on a hit.
// Depends on gbs_pkg.
module gbs_iou
    import gbs_pkg::*;
#(
    parameter int IDX_W = 6
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             clear,
    input  gbs_box_t         cur_box,
    input  logic [15:0]      thr,
    input  gbs_box_t         in_box,
    input  gbs_flags_t       in_flags,
    input  logic [IDX_W-1:0] in_idx,
    input  logic             in_test,
    output gbs_box_t         out_box,
    output gbs_flags_t       out_flags,
    output logic [IDX_W-1:0] out_idx
);

    gbs_box_t         st_box_reg   [IOU_LAT];
    gbs_flags_t       st_flags_reg [IOU_LAT];
    logic [IDX_W-1:0] st_idx_reg   [IOU_LAT];
    logic             st_test_reg  [IOU_LAT];

    logic [29:0] cur_area_reg;
    logic [14:0] iw_reg, ih_reg;
    logic [29:0] inter2_reg, area2_reg;
    logic [29:0] inter3_reg;
    logic [30:0] uni3_reg;
    logic [29:0] inter4_reg;
    logic [46:0] prod4_reg;

    logic signed [17:0] ax1, ax2, bx1, bx2, ay1, ay2, by1, by2;
    logic signed [17:0] x1, x2, y1, y2, dx, dy;
    logic [14:0] iw_next, ih_next;
    logic        hit;

    always_comb
    begin
        ax1 = 18'(cur_box.left);
        ay1 = 18'(cur_box.top);
        bx1 = 18'(in_box.left);
        by1 = 18'(in_box.top);
        ax2 = ax1 + $signed({3'b000, cur_box.width}) - 18'sd1;
        ay2 = ay1 + $signed({3'b000, cur_box.height}) - 18'sd1;
        bx2 = bx1 + $signed({3'b000, in_box.width}) - 18'sd1;
        by2 = by1 + $signed({3'b000, in_box.height}) - 18'sd1;
        x1 = (ax1 > bx1) ? ax1 : bx1;
        y1 = (ay1 > by1) ? ay1 : by1;
        x2 = (ax2 < bx2) ? ax2 : bx2;
        y2 = (ay2 < by2) ? ay2 : by2;
        dx = x2 - x1 + 18'sd1;
        dy = y2 - y1 + 18'sd1;
        // The overlap never exceeds the narrower box, so 15 bits hold it.
        iw_next = (dx > 18'sd0) ? dx[14:0] : 15'd0;
        ih_next = (dy > 18'sd0) ? dy[14:0] : 15'd0;
    end

    assign hit = {1'b0, inter4_reg, 16'd0} > prod4_reg;

    always_ff @(posedge clk)
    begin
        cur_area_reg <= cur_box.width * cur_box.height;
        if (en)
        begin
            iw_reg     <= iw_next;
            ih_reg     <= ih_next;
            inter2_reg <= iw_reg * ih_reg;
            area2_reg  <= st_box_reg[0].width * st_box_reg[0].height;
            inter3_reg <= inter2_reg;
            uni3_reg   <= {1'b0, cur_area_reg} + {1'b0, area2_reg} - {1'b0, inter2_reg};
            inter4_reg <= inter3_reg;
            prod4_reg  <= thr * uni3_reg;
            st_box_reg[0] <= in_box;
            st_idx_reg[0] <= in_idx;
            for (int s = 1; s < IOU_LAT; s++)
            begin
                st_box_reg[s] <= st_box_reg[s-1];
                st_idx_reg[s] <= st_idx_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < IOU_LAT; s++)
            begin
                st_flags_reg[s] <= '0;
                st_test_reg[s]  <= 1'b0;
            end
        end
        else if (clear)
        begin
            for (int s = 0; s < IOU_LAT; s++)
            begin
                st_flags_reg[s] <= '0;
                st_test_reg[s]  <= 1'b0;
            end
        end
        else if (en)
        begin
            st_flags_reg[0] <= in_flags;
            st_test_reg[0]  <= in_test;
            for (int s = 1; s < IOU_LAT; s++)
            begin
                st_flags_reg[s] <= st_flags_reg[s-1];
                st_test_reg[s]  <= st_test_reg[s-1];
            end
        end
    end

    always_comb
    begin
        out_flags         = st_flags_reg[IOU_LAT-1];
        out_flags.removed = st_flags_reg[IOU_LAT-1].removed
                            | (st_test_reg[IOU_LAT-1] & hit);
    end

    assign out_box = st_box_reg[IOU_LAT-1];
    assign out_idx = st_idx_reg[IOU_LAT-1];

endmodule

>>> rtl/greedy_box_suppression_unit.sv
// Top level of the greedy box suppression unit: chain of box cells plus overlap pipeline.
// Depends on gbs_pkg, gbs_ifs, gbs_cell and gbs_iou.
//
//   channel   dir  word
//   boxes     in   box_left, box_top, box_width, box_height, score, final_box
//   results   out  kept_index, last_kept, none_kept, boxes_dropped
//   cfg       in   index, data (0 score_threshold, 1 overlap_threshold)
//
// Loading takes one box per cycle; the new box is sorted into the cell chain at once,
// or dropped when the chain is full. After the final box the chain rotates through the
// overlap pipeline: one full turn per kept box, plus one closing turn that keeps nothing.
// Reset empties the chain and restores the thresholds; no clearing pass is needed.
// A result word waiting on results freezes the rotation; boxes wait while the walk runs.
module greedy_box_suppression_unit
    import gbs_pkg::*;
#(
    parameter int MAX_BOXES = 64
)
(
    input  logic     clk,
    input  logic     rst_n,
    gbs_box_if.sink  boxes,
    gbs_res_if.source results,
    gbs_cfg_if.sink  cfg
);

    localparam int IDX_W    = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W    = $clog2(MAX_BOXES + 1);
    localparam int RING_LEN = MAX_BOXES + IOU_LAT;
    localparam int STEP_W   = $clog2(RING_LEN);

    gbs_state_t state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              kept_pass_reg, kept_pass_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;
    gbs_box_t          cur_box_reg;
    logic [15:0]       score_thr_reg, overlap_thr_reg;

    logic              out_valid_reg, out_valid_next;
    logic [KEEP_W-1:0] out_idx_reg, out_idx_next;
    logic              out_last_reg, out_last_next;
    logic              out_none_reg, out_none_next;
    logic              out_drop_reg, out_drop_next;

    gbs_box_t         cell_box   [MAX_BOXES];
    gbs_flags_t       cell_flags [MAX_BOXES];
    logic [IDX_W-1:0] cell_idx   [MAX_BOXES];
    logic             cell_gt    [MAX_BOXES];

    gbs_box_t         ret_box;
    gbs_flags_t       ret_flags;
    logic [IDX_W-1:0] ret_idx;

    gbs_ctl_t   ctl;
    gbs_box_t   ins_box;
    gbs_flags_t head_flags;
    logic       in_acc, has_room, free, ring_en;
    logic       cand, keep, test, pass_end, finish;

    assign boxes.ready = (state_reg == ST_LOAD);
    assign in_acc      = boxes.valid && boxes.ready;
    assign has_room    = (count_reg < CNT_W'(MAX_BOXES));
    assign free        = !out_valid_reg || results.ready;
    assign ring_en     = (state_reg == ST_WALK) && free;

    assign ins_box = '{left: boxes.box_left, top: boxes.box_top, width: boxes.box_width,
                       height: boxes.box_height, score: boxes.score};

    // Each unfinished box that reaches the head before a keep in a turn is a candidate; once
    // one is kept, every later live box of that turn is tested against it.
    assign cand = ring_en && cell_flags[0].valid && !cell_flags[0].done && !kept_pass_reg;
    assign keep = cand && !cell_flags[0].removed && (cell_box[0].score >= score_thr_reg);
    assign test = cell_flags[0].valid && !cell_flags[0].done && kept_pass_reg
                  && !cell_flags[0].removed;
    assign pass_end = ring_en && (step_reg == STEP_W'(RING_LEN - 1));
    assign finish   = pass_end && !kept_pass_reg && !keep;

    always_comb
    begin
        head_flags      = cell_flags[0];
        head_flags.done = cell_flags[0].done | cand;
    end

    always_comb
    begin
        ctl.load  = in_acc && has_room;
        ctl.shift = ring_en;
        ctl.clear = finish;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_BOXES; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                gbs_cell #(.IDX_W(IDX_W)) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctl        (ctl),
                    .ins_box    (ins_box),
                    .ins_idx    (IDX_W'(count_reg)),
                    .prev_box   (ins_box),
                    .prev_flags ('0),
                    .prev_idx   (IDX_W'(count_reg)),
                    .prev_gt    (1'b0),
                    .next_box   ((MAX_BOXES > 1) ? cell_box[(MAX_BOXES > 1) ? 1 : 0]
                                                  : ret_box),
                    .next_flags ((MAX_BOXES > 1) ? cell_flags[(MAX_BOXES > 1) ? 1 : 0]
                                                  : ret_flags),
                    .next_idx   ((MAX_BOXES > 1) ? cell_idx[(MAX_BOXES > 1) ? 1 : 0]
                                                  : ret_idx),
                    .box        (cell_box[g]),
                    .flags      (cell_flags[g]),
                    .idx        (cell_idx[g]),
                    .gt         (cell_gt[g])
                );
            end
            else if (g == MAX_BOXES - 1)
            begin : g_tail
                gbs_cell #(.IDX_W(IDX_W)) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctl        (ctl),
                    .ins_box    (ins_box),
                    .ins_idx    (IDX_W'(count_reg)),
                    .prev_box   (cell_box[g-1]),
                    .prev_flags (cell_flags[g-1]),
                    .prev_idx   (cell_idx[g-1]),
                    .prev_gt    (cell_gt[g-1]),
                    .next_box   (ret_box),
                    .next_flags (ret_flags),
                    .next_idx   (ret_idx),
                    .box        (cell_box[g]),
                    .flags      (cell_flags[g]),
                    .idx        (cell_idx[g]),
                    .gt         (cell_gt[g])
                );
            end
            else
            begin : g_mid
                gbs_cell #(.IDX_W(IDX_W)) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctl        (ctl),
                    .ins_box    (ins_box),
                    .ins_idx    (IDX_W'(count_reg)),
                    .prev_box   (cell_box[g-1]),
                    .prev_flags (cell_flags[g-1]),
                    .prev_idx   (cell_idx[g-1]),
                    .prev_gt    (cell_gt[g-1]),
                    .next_box   (cell_box[g+1]),
                    .next_flags (cell_flags[g+1]),
                    .next_idx   (cell_idx[g+1]),
                    .box        (cell_box[g]),
                    .flags      (cell_flags[g]),
                    .idx        (cell_idx[g]),
                    .gt         (cell_gt[g])
                );
            end
        end
    endgenerate

    gbs_iou #(.IDX_W(IDX_W)) u_iou (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (ring_en),
        .clear     (finish),
        .cur_box   (cur_box_reg),
        .thr       (overlap_thr_reg),
        .in_box    (cell_box[0]),
        .in_flags  (head_flags),
        .in_idx    (cell_idx[0]),
        .in_test   (test),
        .out_box   (ret_box),
        .out_flags (ret_flags),
        .out_idx   (ret_idx)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        step_next       = step_reg;
        kept_pass_next  = kept_pass_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        out_idx_next    = out_idx_reg;
        out_last_next   = out_last_reg;
        out_none_next   = out_none_reg;
        out_drop_next   = out_drop_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (has_room)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (boxes.final_box)
                    begin
                        state_next      = ST_WALK;
                        step_next       = '0;
                        kept_pass_next  = 1'b0;
                        pend_valid_next = 1'b0;
                    end
                end
            end
            ST_WALK:
            begin
                if (ring_en)
                begin
                    step_next      = pass_end ? '0 : step_reg + STEP_W'(1);
                    kept_pass_next = pass_end ? 1'b0 : (kept_pass_reg | keep);
                    if (keep)
                    begin
                        // A kept box is held back until it is known whether it is the last.
                        pend_valid_next = 1'b1;
                        pend_idx_next   = cell_idx[0];
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_idx_next   = KEEP_W'(pend_idx_reg);
                            out_last_next  = 1'b0;
                            out_none_next  = 1'b0;
                            out_drop_next  = ovf_reg;
                        end
                    end
                    if (finish)
                    begin
                        out_valid_next  = 1'b1;
                        out_idx_next    = pend_valid_reg ? KEEP_W'(pend_idx_reg) : '0;
                        out_last_next   = 1'b1;
                        out_none_next   = !pend_valid_reg;
                        out_drop_next   = ovf_reg;
                        pend_valid_next = 1'b0;
                        count_next      = '0;
                        ovf_next        = 1'b0;
                        state_next      = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            step_reg       <= '0;
            kept_pass_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            step_reg       <= step_next;
            kept_pass_reg  <= kept_pass_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
        out_none_reg <= out_none_next;
        out_drop_reg <= out_drop_next;
        if (keep)
        begin
            cur_box_reg <= cell_box[0];
        end
    end

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_thr_reg   <= SCORE_THR_RESET;
            overlap_thr_reg <= OVERLAP_THR_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_SCORE_THR:   score_thr_reg   <= cfg.data;
                CFG_OVERLAP_THR: overlap_thr_reg <= cfg.data;
                default:         ;
            endcase
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.kept_index    = out_idx_reg;
    assign results.last_kept     = out_last_reg;
    assign results.none_kept     = out_none_reg;
    assign results.boxes_dropped = out_drop_reg;

endmodule

>>> test/gbs_scoreboard.sv
// Scoreboard class for the greedy box suppression unit testbench.
// Depends on gbs_pkg; holds its own copy of the suppression state and thresholds.
`timescale 1ns / 100ps

package gbs_tb_pkg;
    import gbs_pkg::*;

    typedef struct {
        logic [5:0] kept_index;
        logic       last_kept;
        logic       none_kept;
        logic       boxes_dropped;
    } kept_word_t;

    class gbs_scoreboard;
        int unsigned capacity;
        logic [15:0] score_thr;
        logic [15:0] overlap_thr;
        gbs_box_t    stored[$];
        bit          dropped;
        kept_word_t  pending_words[$];
        int          errors;
        int          words_checked;
        int          runs_closed;

        function new(int unsigned cap);
            capacity    = cap;
            score_thr   = SCORE_THR_RESET;
            overlap_thr = OVERLAP_THR_RESET;
            dropped     = 0;
            errors      = 0;
            words_checked = 0;
            runs_closed = 0;
        endfunction

        function void write_reg(logic [3:0] idx, logic [15:0] val);
            if (idx == CFG_SCORE_THR)
                score_thr = val;
            else if (idx == CFG_OVERLAP_THR)
                overlap_thr = val;
        endfunction

        function bit iou_exceeds(gbs_box_t a, gbs_box_t b);
            longint x1, y1, x2, y2, iw, ih, inter, uni, ax2, bx2, ay2, by2;
            x1 = (a.left > b.left) ? a.left : b.left;
            y1 = (a.top > b.top) ? a.top : b.top;
            ax2 = longint'(a.left) + longint'(a.width) - 1;
            bx2 = longint'(b.left) + longint'(b.width) - 1;
            ay2 = longint'(a.top) + longint'(a.height) - 1;
            by2 = longint'(b.top) + longint'(b.height) - 1;
            x2 = (ax2 < bx2) ? ax2 : bx2;
            y2 = (ay2 < by2) ? ay2 : by2;
            iw = (x2 - x1 + 1 > 0) ? x2 - x1 + 1 : 0;
            ih = (y2 - y1 + 1 > 0) ? y2 - y1 + 1 : 0;
            inter = iw * ih;
            uni = longint'(a.width) * longint'(a.height)
                  + longint'(b.width) * longint'(b.height) - inter;
            return inter * 65536 > longint'(overlap_thr) * uni;
        endfunction

        // Notes one accepted box; a final box triggers the greedy walk.
        function void note_box(gbs_box_t b, bit fin);
            int order[$];
            bit removed[$];
            int n, k, bi, kept;
            kept_word_t w;
            if (stored.size() < capacity)
                stored.insert(stored.size(), b);
            else
                dropped = 1;
            if (!fin)
                return;
            n = stored.size();
            for (int i = 0; i < n; i++)
            begin
                k = order.size();
                while (k > 0 && stored[order[k-1]].score < stored[i].score)
                    k--;
                order.insert(k, i);
                removed.insert(removed.size(), 1'b0);
            end
            kept = 0;
            for (int i = 0; i < n; i++)
            begin
                bi = order[i];
                if (removed[bi] || stored[bi].score < score_thr)
                    continue;
                w.kept_index = bi[5:0];
                w.last_kept = 0;
                w.none_kept = 0;
                w.boxes_dropped = dropped;
                pending_words.insert(pending_words.size(), w);
                kept++;
                for (int j = i + 1; j < n; j++)
                    if (!removed[order[j]] && iou_exceeds(stored[bi], stored[order[j]]))
                        removed[order[j]] = 1;
            end
            if (kept == 0)
            begin
                w.kept_index = 0;
                w.last_kept = 1;
                w.none_kept = 1;
                w.boxes_dropped = dropped;
                pending_words.insert(pending_words.size(), w);
            end
            else
                pending_words[pending_words.size()-1].last_kept = 1;
            stored.delete();
            dropped = 0;
            runs_closed++;
        endfunction

        function void check_word(kept_word_t got);
            kept_word_t e;
            if (pending_words.size() == 0)
            begin
                $error("result word with no expectation: index %0d", got.kept_index);
                errors++;
                return;
            end
            e = pending_words.pop_front();
            words_checked++;
            if (got.kept_index !== e.kept_index)
            begin
                $error("kept_index: expected %0d, got %0d", e.kept_index, got.kept_index);
                errors++;
            end
            if (got.last_kept !== e.last_kept)
            begin
                $error("last_kept: expected %0b, got %0b", e.last_kept, got.last_kept);
                errors++;
            end
            if (got.none_kept !== e.none_kept)
            begin
                $error("none_kept: expected %0b, got %0b", e.none_kept, got.none_kept);
                errors++;
            end
            if (got.boxes_dropped !== e.boxes_dropped)
            begin
                $error("boxes_dropped: expected %0b, got %0b", e.boxes_dropped,
                       got.boxes_dropped);
                errors++;
            end
        endfunction
    endclass
endpackage

>>> test/greedy_box_suppression_unit_tb.sv
// Testbench top for the greedy box suppression unit: random box runs with idling.
// Depends on gbs_pkg, gbs_ifs, gbs_tb_pkg and the unit's RTL.
`timescale 1ns / 100ps

module greedy_box_suppression_unit_tb;
    import gbs_pkg::*;
    import gbs_tb_pkg::*;

    localparam int CAP = 64;
    localparam longint CYCLE_LIMIT = 3000000;

    logic clk;
    logic rst_n;
    longint cycles;
    bit hold_results;
    bit stim_done;
    gbs_scoreboard board;

    gbs_box_if boxes ();
    gbs_res_if results ();
    gbs_cfg_if cfg ();

    greedy_box_suppression_unit #(.MAX_BOXES(CAP)) dut (
        .clk(clk), .rst_n(rst_n), .boxes(boxes), .results(results), .cfg(cfg)
    );

    initial clk = 0;
    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[greedy_box_suppression_unit] ERROR");
            $finish;
        end
    end

    // Sampling at the rising edge: accepted boxes feed the predictor, words get checked.
    always @(posedge clk)
    begin
        gbs_box_t b;
        kept_word_t w;
        if (rst_n && boxes.valid && boxes.ready)
        begin
            b.left = boxes.box_left;
            b.top = boxes.box_top;
            b.width = boxes.box_width;
            b.height = boxes.box_height;
            b.score = boxes.score;
            board.note_box(b, boxes.final_box);
        end
        if (rst_n && results.valid && results.ready)
        begin
            w.kept_index = results.kept_index;
            w.last_kept = results.last_kept;
            w.none_kept = results.none_kept;
            w.boxes_dropped = results.boxes_dropped;
            board.check_word(w);
        end
    end

    // Receiver: random stalls per word, or a long hold-off when asked.
    initial
    begin
        int gap;
        results.ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_results)
                results.ready <= 0;
            else if (results.ready && !results.valid)
                ;
            else
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
                if (results.ready && results.valid)
                    gap = gap;
                if (gap == 0 || $urandom_range(0, 7) < 1)
                    results.ready <= 1;
                else
                begin
                    results.ready <= 0;
                    repeat (gap) @(negedge clk);
                    if (!hold_results)
                        results.ready <= 1;
                end
            end
        end
    end

    // Valid stays high between back-to-back boxes; idle gaps and drain() lower it.
    task automatic send_box(logic signed [15:0] l, logic signed [15:0] t,
                            logic [14:0] w, logic [14:0] h, logic [15:0] s, bit fin,
                            bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            boxes.valid <= 0;
            repeat (gap) @(negedge clk);
        end
        boxes.valid <= 1;
        boxes.box_left <= l;
        boxes.box_top <= t;
        boxes.box_width <= w;
        boxes.box_height <= h;
        boxes.score <= s;
        boxes.final_box <= fin;
        @(posedge clk);
        while (!boxes.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic random_box(bit fin, bit near);
        logic signed [15:0] l, t;
        logic [14:0] w, h;
        if (near)
        begin
            l = 16'($urandom_range(0, 60));
            t = 16'($urandom_range(0, 60));
            w = 15'($urandom_range(0, 40));
            h = 15'($urandom_range(0, 40));
        end
        else
        begin
            l = 16'($urandom);
            t = 16'($urandom);
            w = 15'($urandom);
            h = 15'($urandom);
        end
        send_box(l, t, w, h, 16'($urandom), fin, 0);
    endtask

    task automatic drain();
        boxes.valid <= 0;
        while (board.pending_words.size() != 0) @(posedge clk);
        // Every expected word has been checked here; the extra wait only keeps the unit idle.
        repeat (4 * (CAP + IOU_LAT)) @(posedge clk);
    endtask

    task automatic write_reg(logic [3:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg.valid <= 1;
        cfg.index <= idx;
        cfg.data <= val;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        board.write_reg(idx, val);
        @(negedge clk);
        cfg.valid <= 0;
    endtask

    initial
    begin
        int n, sent;
        board = new(CAP);
        cycles = 0;
        hold_results = 0;
        stim_done = 0;
        rst_n = 0;
        boxes.valid = 0;
        boxes.box_left = 0;
        boxes.box_top = 0;
        boxes.box_width = 0;
        boxes.box_height = 0;
        boxes.score = 0;
        boxes.final_box = 0;
        cfg.valid = 0;
        cfg.index = 0;
        cfg.data = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: reset thresholds, lone box, extremes, ties, equal boxes.
        send_box(16'sh8000, 16'sh8000, 15'h7fff, 15'h7fff, 16'hffff, 1, 0);
        send_box(16'sh7fff, 16'sh7fff, 0, 0, 0, 1, 0);
        send_box(10, 10, 20, 20, 40000, 0, 0);
        send_box(10, 10, 20, 20, 40000, 0, 0);
        send_box(12, 12, 20, 20, 50000, 0, 0);
        send_box(0, 0, 0, 0, 60000, 0, 0);
        send_box(0, 0, 0, 0, 60000, 0, 0);
        send_box(100, 100, 5, 5, 19661, 0, 0);
        send_box(100, 100, 5, 5, 19660, 1, 0);
        drain();
        write_reg(CFG_SCORE_THR, 0);
        write_reg(CFG_OVERLAP_THR, 0);
        send_box(0, 0, 4, 4, 0, 0, 0);
        send_box(3, 3, 4, 4, 0, 0, 0);
        send_box(50, 50, 4, 4, 1, 1, 0);
        drain();
        write_reg(CFG_SCORE_THR, 16'hffff);
        write_reg(CFG_OVERLAP_THR, 16'hffff);
        write_reg(4'd9, 16'h1234);
        send_box(0, 0, 4, 4, 16'hffff, 0, 0);
        send_box(0, 0, 4, 4, 16'hfffe, 1, 0);
        drain();
        sent = 14;

        // Overflow with long receiver hold-off: capacity plus a few, back to back.
        write_reg(CFG_SCORE_THR, 0);
        write_reg(CFG_OVERLAP_THR, 16'h8000);
        hold_results = 1;
        fork
            begin
                repeat (3000) @(posedge clk);
                hold_results = 0;
            end
        join_none
        for (int i = 0; i < CAP + 3; i++)
            send_box(16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)),
                     15'($urandom_range(1, 60)), 15'($urandom_range(1, 60)),
                     16'($urandom), i == CAP + 2, 1);
        for (int r = 0; r < 6; r++)
            random_box(r == 5, 1);
        sent += CAP + 9;
        wait (!hold_results);
        drain();

        // Random runs of small sets, thresholds changed between phases.
        while (sent < 430)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                drain();
                write_reg(CFG_SCORE_THR, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                         : 16'($urandom_range(0, 30000)));
                write_reg(CFG_OVERLAP_THR, 16'($urandom));
            end
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++)
                random_box(i == n - 1, $urandom_range(0, 4) != 0);
            sent += n;
        end
        stim_done = 1;
        drain();
        $display("Covered %0d boxes in %0d runs, %0d result words checked.",
                 sent, board.runs_closed, board.words_checked);
        if (board.errors == 0 && board.pending_words.size() == 0)
            $display("[greedy_box_suppression_unit] OK");
        else
            $display("[greedy_box_suppression_unit] ERROR");
        $finish;
    end
endmodule

>>> sim.f
rtl/gbs_pkg.sv
rtl/gbs_ifs.sv
rtl/gbs_cell.sv
rtl/gbs_iou.sv
rtl/greedy_box_suppression_unit.sv
test/gbs_scoreboard.sv
test/greedy_box_suppression_unit_tb.sv
